/* rtl/aesr_pkg.sv */
// Package for the AES encryption round: payload structs, mode codes,
// S-box and GF(2^8) helpers. No dependencies.
package aesr_pkg;

  localparam logic [1:0] MODE_FULL   = 2'd0;
  localparam logic [1:0] MODE_FINAL  = 2'd1;
  localparam logic [1:0] MODE_ARK    = 2'd2;
  // unused code, treated as key addition only
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [7:0] GF_POLY = 8'h1B;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] state_hi;
    logic [63:0] state_lo;
    logic [63:0] round_key_hi;
    logic [63:0] round_key_lo;
  } aesr_in_t;

  typedef struct packed {
    logic [63:0] state_out_hi;
    logic [63:0] state_out_lo;
  } aesr_out_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
  endfunction

endpackage

/* rtl/aesr_datapath.sv */
// Combinational round datapath: SubBytes, ShiftRows, MixColumns, AddRoundKey; mode picks the steps.
// Depends on aesr_pkg.
module aesr_datapath
  import aesr_pkg::*;
(
  input  aesr_in_t  req,
  output aesr_out_t res
);

  logic [7:0] b   [16];
  logic [7:0] ss  [16];
  logic [7:0] mc  [16];
  logic [7:0] sel [16];
  logic [7:0] all [4];
  logic [127:0] packed_st;

  always_comb begin
    for (int n = 0; n < 8; n++) begin
      b[n]     = req.state_hi[56-8*n +: 8];
      b[n + 8] = req.state_lo[56-8*n +: 8];
    end
    // byte (c,r) takes the S-box of column c+r, row r
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        ss[4*c + r] = SBOX[b[4*((c + r) % 4) + r]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      all[c] = ss[4*c] ^ ss[4*c+1] ^ ss[4*c+2] ^ ss[4*c+3];
      for (int r = 0; r < 4; r++) begin
        mc[4*c + r] = ss[4*c + r] ^ all[c]
                    ^ xtime(ss[4*c + r] ^ ss[4*c + ((r + 1) % 4)]);
      end
    end
    for (int n = 0; n < 16; n++) begin
      case (req.mode)
        MODE_FULL:  sel[n] = mc[n];
        MODE_FINAL: sel[n] = ss[n];
        default:    sel[n] = b[n];
      endcase
    end
    for (int n = 0; n < 16; n++) begin
      packed_st[120-8*n +: 8] = sel[n];
    end
  end

  assign res.state_out_hi = packed_st[127:64] ^ req.round_key_hi;
  assign res.state_out_lo = packed_st[63:0]   ^ req.round_key_lo;

endmodule

/* rtl/aes_encrypt_round.sv */
// Top level of the AES encryption round: input register, round datapath,
// output register. Depends on aesr_pkg and aesr_datapath.
//
//   channel | ports                     | payload
//   input   | in_valid, in_stall, in_req | aesr_in_t
//   output  | out_valid, out_stall, out_res | aesr_out_t
//
// One request per cycle sustained while out_stall is low; a request passes
// the input register, then the result register, with the whole round done in between.
// Reset (rst_n, synchronous) clears both valid flags only.
// Each stage advances when its successor is empty or moving; a stall on
// the output backs up through both stages without losing a request.
module aes_encrypt_round
  import aesr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  aesr_in_t  in_req,
  output logic      out_valid,
  input  logic      out_stall,
  output aesr_out_t out_res
);

  logic      s1_valid_r;
  aesr_in_t  s1_req_r;
  aesr_out_t s1_res;
  logic      s2_valid_r;
  aesr_out_t s2_res_r;
  logic      s2_take;
  logic      s1_take;

  assign s2_take  = s1_valid_r && (!s2_valid_r || !out_stall);
  assign s1_take  = !s1_valid_r || s2_take;
  assign in_stall = !s1_take;

  aesr_datapath u_dp (
    .req (s1_req_r),
    .res (s1_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_take) begin
        s1_valid_r <= in_valid;
      end
      if (s2_take) begin
        s2_valid_r <= 1'b1;
      end else if (!out_stall) begin
        s2_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && in_valid) begin
      s1_req_r <= in_req;
    end
    if (s2_take) begin
      s2_res_r <= s1_res;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_res   = s2_res_r;

endmodule
